FILE: hdl/atsc_cc_caption_extractor_unit_defines.svh
// assertion macros used by the caption extractor back end
`ifndef ATSC_CC_CAPTION_EXTRACTOR_UNIT_DEFINES_SVH
`define ATSC_CC_CAPTION_EXTRACTOR_UNIT_DEFINES_SVH

// property that holds at every clock edge outside reset
`define ATSC_CC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define ATSC_CC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/atsc_cc_pkg.sv
package atsc_cc_pkg;

  typedef enum logic [1:0] {
    StPair   = 2'd0,
    StHeader = 2'd1,
    StMarker = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    CfgSelectEnable  = 1'b0,
    CfgSelectedTrack = 1'b1
  } cfg_index_e;

  typedef enum logic [1:0] {
    PhMarker = 2'd0,
    PhFirst  = 2'd1,
    PhSecond = 2'd2
  } phase_e;

  localparam logic [6:0] PosLastHdr = 7'd7;
  localparam logic [6:0] PosFlags   = 7'd8;
  localparam logic [6:0] PosEm      = 7'd9;
  localparam logic [6:0] PosFirstPkt = 7'd10;
  localparam logic [6:0] PosMax     = 7'd127;
  localparam logic [4:0] MarkerBits = 5'h1f;
  localparam logic [2:0] CtrlHigh   = 3'b001;
  localparam logic [2:0] NumTracks  = 3'd4;

  typedef struct packed {
    status_e    kind;
    logic [6:0] cc_one;
    logic [6:0] cc_two;
    logic       field;
  } cc_op_t;

  typedef struct packed {
    logic       select_enable;
    logic [1:0] selected_track;
  } cc_cfg_t;

  typedef struct packed {
    status_e    status;
    logic [6:0] cc_byte_one;
    logic [6:0] cc_byte_two;
    logic       field_type;
    logic [1:0] pair_channel;
    logic       channel_code;
    logic       track_added;
    logic       selected_match;
  } cc_result_t;

  // ga94 user data header: b5 0031 'GA94' 03
  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] val;
    case (idx)
      3'd0: val = 8'hB5;
      3'd1: val = 8'h00;
      3'd2: val = 8'h31;
      3'd3: val = 8'h47;
      3'd4: val = 8'h41;
      3'd5: val = 8'h39;
      3'd6: val = 8'h34;
      default: val = 8'h03;
    endcase
    return val;
  endfunction

endpackage

FILE: hdl/atsc_cc_front.sv
module atsc_cc_front import atsc_cc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] data_byte_i,
  input  logic       payload_start_i,
  output logic       push_o,
  output cc_op_t     push_op_o
);

  logic [6:0] pos_q, pos_d, pos;
  logic       hg_q, hg_d, hg, hg_n;
  logic       pf_q, pf_d, pf;
  logic [4:0] pl_q, pl_d, pl, pl_n;
  logic [9:0] hold_q, hold_d;
  phase_e     phase_q, phase_d, phase_nx;
  logic [6:0] d1;
  logic [6:0] d2;

  always_comb begin
    pos = payload_start_i ? '0 : pos_q;
    hg  = payload_start_i ? 1'b1 : hg_q;
    pf  = payload_start_i ? 1'b0 : pf_q;
    pl  = payload_start_i ? '0 : pl_q;
    hg_n = hg & (data_byte_i == hdr_byte(pos[2:0]));
    pl_n = pl - 5'd1;
    d1 = hold_q[9:3];
    d2 = data_byte_i[6:0];
    case (phase_q)
      PhMarker: phase_nx = PhFirst;
      PhFirst:  phase_nx = PhSecond;
      default:  phase_nx = PhMarker;
    endcase

    pos_d   = pos_q;
    hg_d    = hg_q;
    pf_d    = pf_q;
    pl_d    = pl_q;
    hold_d  = hold_q;
    phase_d = phase_q;
    push_o  = 1'b0;
    push_op_o = '0;

    if (accept_i) begin
      pos_d   = (pos == PosMax) ? pos : pos + 7'd1;
      hg_d    = hg;
      pf_d    = pf;
      pl_d    = pl;
      phase_d = (pos < PosFirstPkt) ? PhMarker : phase_nx;
      if (pos < PosFlags) begin
        hg_d = hg_n;
        if (pos == PosLastHdr && !hg_n) begin
          push_o = 1'b1;
          push_op_o.kind = StHeader;
        end
      end else if (hg) begin
        if (pos == PosFlags) begin
          pl_d = data_byte_i[4:0];
          pf_d = data_byte_i[6] && (data_byte_i[4:0] != '0);
        end else if (pos != PosEm && pf) begin
          case (phase_q)
            PhMarker: begin
              if (data_byte_i[7:3] != MarkerBits) begin
                pf_d = 1'b0;
                pl_d = '0;
                push_o = 1'b1;
                push_op_o.kind = StMarker;
              end else begin
                hold_d[2:0] = data_byte_i[2:0];
              end
            end
            PhFirst: begin
              hold_d[9:3] = data_byte_i[6:0];
            end
            default: begin
              pl_d = pl_n;
              if (pl_n == '0) begin
                pf_d = 1'b0;
              end
              // valid field 1/2 pair that is not a null pad
              if (hold_q[2] && !hold_q[1] && !(d1[6:4] == '0 && d2[6:4] == '0)) begin
                push_o = 1'b1;
                push_op_o.kind   = StPair;
                push_op_o.cc_one = d1;
                push_op_o.cc_two = d2;
                push_op_o.field  = hold_q[0];
              end
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      hg_q    <= 1'b1;
      pf_q    <= 1'b0;
      pl_q    <= '0;
      phase_q <= PhMarker;
    end else begin
      pos_q   <= pos_d;
      hg_q    <= hg_d;
      pf_q    <= pf_d;
      pl_q    <= pl_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
  end

endmodule

FILE: hdl/atsc_cc_queue.sv
module atsc_cc_queue import atsc_cc_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  cc_op_t push_op_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output cc_op_t op_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cc_op_t          entry_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == FullCnt);
  assign valid_o = (count_q != '0);
  assign op_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

endmodule

FILE: hdl/atsc_cc_back.sv
`include "atsc_cc_caption_extractor_unit_defines.svh"

module atsc_cc_back import atsc_cc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cc_cfg_t    cfg_i,
  input  logic       q_valid_i,
  input  cc_op_t     q_op_i,
  output logic       q_pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output cc_result_t result_o
);

  logic [3:0] seen_q, seen_d;
  logic [2:0] tracks_q, tracks_d;
  logic [1:0] rc_q, rc_d;
  logic [1:0] tct_q [4];
  logic       out_valid_q, out_valid_d;
  cc_result_t result_q, result_d;
  logic       pop, is_pair, is_code, added;
  logic [1:0] ch, sel_chan;

  assign pop     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign q_pop_o = pop;

  always_comb begin
    is_pair = (q_op_i.kind == StPair);
    is_code = is_pair && (q_op_i.cc_one[6:4] == CtrlHigh);
    ch      = {q_op_i.field, q_op_i.cc_one[3]};
    added   = is_code && !seen_q[ch] && (tracks_q != NumTracks);

    seen_d   = seen_q;
    tracks_d = tracks_q;
    rc_d     = rc_q;
    if (added) begin
      seen_d[ch] = 1'b1;
      tracks_d   = tracks_q + 3'd1;
    end
    if (is_code) begin
      rc_d = ch;
    end
    sel_chan = (added && tracks_q[1:0] == cfg_i.selected_track) ? ch
                                                                : tct_q[cfg_i.selected_track];

    result_d = '0;
    result_d.status = q_op_i.kind;
    if (is_pair) begin
      result_d.cc_byte_one    = q_op_i.cc_one;
      result_d.cc_byte_two    = q_op_i.cc_two;
      result_d.field_type     = q_op_i.field;
      result_d.pair_channel   = rc_d;
      result_d.channel_code   = is_code;
      result_d.track_added    = added;
      result_d.selected_match = cfg_i.select_enable
                                && ({1'b0, cfg_i.selected_track} < tracks_d)
                                && (rc_d == sel_chan);
    end

    out_valid_d = pop ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= '0;
      tracks_q    <= '0;
      rc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop && is_pair) begin
        seen_q   <= seen_d;
        tracks_q <= tracks_d;
        rc_q     <= rc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      result_q <= result_d;
    end
    if (pop && added) begin
      tct_q[tracks_q[1:0]] <= ch;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  `ATSC_CC_ASSERT(a_seen_matches_tracks, $countones(seen_q) == int'(tracks_q), "seen count mismatch")
  `ATSC_CC_ASSERT_NEXT(a_status_fields_clear, pop && q_op_i.kind != StPair, out_valid_q && result_q.cc_byte_one == '0 && !result_q.track_added && !result_q.selected_match, "status transaction carries pair data")
  `ATSC_CC_ASSERT_NEXT(a_track_count_steps, pop && added, tracks_q == $past(tracks_q) + 3'd1, "track count did not advance")

endmodule

FILE: hdl/atsc_cc_caption_extractor_unit.sv
// a result is registered in the op queue and then in the back end's output register
// throughput: one byte per cycle while the op queue is not full; one result at most per byte
// the front parser stalls only when the op queue (QueueDepth entries) is full
// reset: asynchronous, clears parser and channel/track state, header flag set, no clearing pass
// configuration registers reset to zero and are always ready
module atsc_cc_caption_extractor_unit import atsc_cc_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       payload_start_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [6:0] cc_byte_one_o,
  output logic [6:0] cc_byte_two_o,
  output logic       field_type_o,
  output logic [1:0] pair_channel_o,
  output logic       channel_code_o,
  output logic       track_added_o,
  output logic       selected_match_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [1:0] cfg_data_i
);

  cc_cfg_t    cfg_q, cfg_d;
  logic       accept, push, full, q_valid, q_pop;
  cc_op_t     push_op, q_op;
  cc_result_t result;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgSelectEnable:  cfg_d.select_enable  = cfg_data_i[0];
        CfgSelectedTrack: cfg_d.selected_track = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  atsc_cc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .payload_start_i (payload_start_i),
    .push_o          (push),
    .push_op_o       (push_op)
  );

  atsc_cc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .op_o      (q_op)
  );

  atsc_cc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_op_i      (q_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign status_o         = result.status;
  assign cc_byte_one_o    = result.cc_byte_one;
  assign cc_byte_two_o    = result.cc_byte_two;
  assign field_type_o     = result.field_type;
  assign pair_channel_o   = result.pair_channel;
  assign channel_code_o   = result.channel_code;
  assign track_added_o    = result.track_added;
  assign selected_match_o = result.selected_match;

endmodule

FILE: bench/atsc_cc_caption_extractor_unit_tb.sv
module atsc_cc_caption_extractor_unit_tb import atsc_cc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] GaHeader = 64'hB5_00_31_47_41_39_34_03;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles = 8;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       payload_start_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] status_o;
  logic [6:0] cc_byte_one_o;
  logic [6:0] cc_byte_two_o;
  logic       field_type_o;
  logic [1:0] pair_channel_o;
  logic       channel_code_o;
  logic       track_added_o;
  logic       selected_match_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [0:0] cfg_index_i;
  logic [1:0] cfg_data_i;

  atsc_cc_caption_extractor_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .payload_start_i  (payload_start_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .status_o         (status_o),
    .cc_byte_one_o    (cc_byte_one_o),
    .cc_byte_two_o    (cc_byte_two_o),
    .field_type_o     (field_type_o),
    .pair_channel_o   (pair_channel_o),
    .channel_code_o   (channel_code_o),
    .track_added_o    (track_added_o),
    .selected_match_o (selected_match_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  // parser and channel tracking shadow state
  logic [6:0]  pos_q;
  logic        hdr_ok;
  logic        proc_on;
  logic [4:0]  pkts_left;
  logic [10:0] pkt_hold;
  logic [1:0]  cur_chan;
  logic [2:0]  chan_track [4];
  logic [1:0]  track_chan [4];
  logic [2:0]  n_tracks;
  logic        sel_en;
  logic [1:0]  sel_track;

  cc_result_t pending_captions [$];
  logic [8:0] payload_q [$];

  int send_idle_pct;
  int recv_stall_pct;
  int holdoff_req;
  int holdoff_left;
  int bytes_accepted;
  int pairs_checked;
  int errors_checked;
  int mismatch_count;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("timeout with %0d transactions still expected", pending_captions.size());
    $display("atsc_cc_caption_extractor_unit_tb: FAIL");
    $finish;
  end

  task automatic parse_user_data_byte(input logic [7:0] b, input logic st);
    logic [6:0] p;
    logic [6:0] d1;
    logic [6:0] d2;
    logic [1:0] kind;
    logic [1:0] ch;
    int unsigned rel;
    phase_e ph;
    cc_result_t r;
    if (st) begin
      pos_q = '0;
      hdr_ok = 1'b1;
      proc_on = 1'b0;
      pkts_left = '0;
    end
    p = pos_q;
    if (pos_q < PosMax) pos_q = pos_q + 7'd1;
    r = '0;
    if (p <= PosLastHdr) begin
      if (b != GaHeader[63 - 8 * p -: 8]) hdr_ok = 1'b0;
      if (p == PosLastHdr && !hdr_ok) begin
        r.status = StHeader;
        pending_captions.insert(pending_captions.size(), r);
      end
      return;
    end
    if (!hdr_ok) return;
    if (p == PosFlags) begin
      proc_on = b[6];
      pkts_left = b[4:0];
      if (pkts_left == 5'd0) proc_on = 1'b0;
      return;
    end
    if (p == PosEm || !proc_on) return;
    rel = (p - PosFirstPkt) % 3;
    ph = phase_e'(rel[1:0]);
    case (ph)
      PhMarker: begin
        if (b[7:3] != MarkerBits) begin
          proc_on = 1'b0;
          pkts_left = '0;
          r.status = StMarker;
          pending_captions.insert(pending_captions.size(), r);
        end else begin
          pkt_hold = {8'd0, b[2:0]};
        end
      end
      PhFirst: begin
        pkt_hold = {1'b0, b[6:0], pkt_hold[2:0]};
      end
      default: begin
        d1 = pkt_hold[9:3];
        d2 = b[6:0];
        kind = pkt_hold[1:0];
        pkts_left = pkts_left - 5'd1;
        if (pkts_left == 5'd0) proc_on = 1'b0;
        if (!pkt_hold[2] || kind[1] || (d1 < 7'h10 && d2 < 7'h10)) return;
        r.status = StPair;
        r.cc_byte_one = d1;
        r.cc_byte_two = d2;
        r.field_type = kind[0];
        if (d1[6:4] == CtrlHigh) begin
          ch = {kind[0], d1[3]};
          r.channel_code = 1'b1;
          if (chan_track[ch] >= NumTracks && n_tracks < NumTracks) begin
            chan_track[ch] = n_tracks;
            track_chan[n_tracks[1:0]] = ch;
            n_tracks = n_tracks + 3'd1;
            r.track_added = 1'b1;
          end
          cur_chan = ch;
        end
        r.pair_channel = cur_chan;
        r.selected_match = sel_en && ({1'b0, sel_track} < n_tracks) &&
                           (cur_chan == track_chan[sel_track]);
        pending_captions.insert(pending_captions.size(), r);
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk_i) begin : result_check
    cc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_captions.size() == 0) begin
        report_mismatch("unexpected transaction, status", status_o, 0);
      end else begin
        want = pending_captions.pop_front();
        if (want.status == StPair) pairs_checked++;
        else errors_checked++;
        if (status_o !== want.status)
          report_mismatch("status", status_o, want.status);
        if (cc_byte_one_o !== want.cc_byte_one)
          report_mismatch("cc_byte_one", cc_byte_one_o, want.cc_byte_one);
        if (cc_byte_two_o !== want.cc_byte_two)
          report_mismatch("cc_byte_two", cc_byte_two_o, want.cc_byte_two);
        if (field_type_o !== want.field_type)
          report_mismatch("field_type", field_type_o, want.field_type);
        if (pair_channel_o !== want.pair_channel)
          report_mismatch("pair_channel", pair_channel_o, want.pair_channel);
        if (channel_code_o !== want.channel_code)
          report_mismatch("channel_code", channel_code_o, want.channel_code);
        if (track_added_o !== want.track_added)
          report_mismatch("track_added", track_added_o, want.track_added);
        if (selected_match_o !== want.selected_match)
          report_mismatch("selected_match", selected_match_o, want.selected_match);
      end
    end
  end

  // receiver side: random stalls plus an optional long hold-off
  always @(negedge clk_i) begin
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req = 0;
    end
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    payload_start_i <= st;
    do @(posedge clk_i); while (in_stall_o);
    parse_user_data_byte(b, st);
    bytes_accepted++;
  endtask

  task automatic send_payload(input logic first_start);
    int i;
    if (payload_q.size() != 0) payload_q[0][8] = payload_q[0][8] | first_start;
    for (i = 0; i < payload_q.size(); i++) send_byte(payload_q[i][7:0], payload_q[i][8]);
    payload_q.delete();
  endtask

  task automatic add_byte(input logic [7:0] b);
    payload_q.insert(payload_q.size(), {1'b0, b});
  endtask

  task automatic add_header(input int corrupt_at, input logic [7:0] flip);
    int i;
    logic [7:0] h;
    for (i = 0; i < 8; i++) begin
      h = GaHeader[63 - 8 * i -: 8];
      if (i == corrupt_at) h = h ^ flip;
      add_byte(h);
    end
  endtask

  task automatic add_packet(input logic [7:0] mark, input logic [7:0] one,
                            input logic [7:0] two);
    add_byte(mark);
    add_byte(one);
    add_byte(two);
  endtask

  task automatic add_caption_packet();
    logic [31:0] rnd;
    logic [7:0] mark;
    logic [7:0] one;
    logic [7:0] two;
    int pick;
    rnd = $urandom;
    mark = {MarkerBits, 3'b100};
    if (rnd[3:0] == 4'd0) mark[2] = 1'b0;
    mark[0] = rnd[4];
    mark[1] = (rnd[7:5] == 3'd0);
    one = rnd[15:8];
    two = rnd[23:16];
    pick = $urandom_range(9);
    if (pick < 4) begin
      one[6:4] = CtrlHigh;
    end else if (pick < 7) begin
      if (one[6:5] == 2'd0) one[5] = 1'b1;
    end else begin
      one[6:4] = 3'd0;
      if (rnd[24]) two[6:4] = 3'd0;
    end
    add_packet(mark, one, two);
  endtask

  task automatic build_caption_payload(input int pkt_count);
    logic [7:0] flags;
    int i;
    payload_q.delete();
    add_header(-1, 8'h00);
    flags = 8'($urandom);
    flags[6] = 1'b1;
    flags[4:0] = pkt_count[4:0];
    add_byte(flags);
    add_byte(8'($urandom));
    for (i = 0; i < pkt_count; i++) add_caption_packet();
  endtask

  task automatic send_random_payload();
    int k;
    int n;
    int j;
    logic [31:0] rnd;
    logic first;
    k = $urandom_range(99);
    n = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 6);
    first = ($urandom_range(19) != 0);
    build_caption_payload(n);
    if (k < 70) begin
      // well formed
    end else if (k < 76) begin
      j = $urandom_range(7);
      payload_q[j][7:0] = payload_q[j][7:0] ^ 8'($urandom_range(1, 255));
    end else if (k < 80) begin
      payload_q[PosFlags][6] = 1'b0;
    end else if (k < 83) begin
      payload_q[PosFlags][4:0] = 5'd0;
    end else if (k < 89 && n > 0) begin
      j = PosFirstPkt + 3 * $urandom_range(n - 1);
      payload_q[j][7:3] = 5'($urandom_range(30));
    end else if (k < 94) begin
      j = $urandom_range(1, payload_q.size() - 1);
      while (payload_q.size() > j) void'(payload_q.pop_back());
    end else begin
      payload_q.delete();
      repeat ($urandom_range(1, 24)) begin
        rnd = $urandom;
        payload_q.insert(payload_q.size(), {(rnd[10:8] == 3'd0), rnd[7:0]});
      end
      first = 1'b0;
    end
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 4)) add_byte(8'($urandom));
    send_payload(first);
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_captions.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input cfg_index_e idx, input logic [1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgSelectEnable) sel_en = value[0];
    else sel_track = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_special_cases();
    int i;
    send_idle_pct = 30;
    recv_stall_pct = 79;
    // bytes right after reset without a payload start
    add_header(-1, 8'h00);
    add_byte(8'h42);
    add_byte(8'hFF);
    add_packet(8'hFC, 8'h94, 8'h2C);
    add_packet(8'hFD, 8'h9C, 8'h20);
    send_payload(1'b0);
    // header mismatches, rest of the payload ignored
    add_header(3, 8'h0F);
    add_byte(8'h41);
    add_byte(8'hFF);
    add_packet(8'hFC, 8'h94, 8'h20);
    send_payload(1'b1);
    add_header(0, 8'hB5);
    add_byte(8'hFF);
    add_byte(8'hFF);
    send_payload(1'b1);
    // process flag clear, then zero packet count
    add_header(-1, 8'h00);
    add_byte(8'h02);
    add_byte(8'hFF);
    add_packet(8'hFC, 8'h94, 8'h20);
    send_payload(1'b1);
    add_header(-1, 8'h00);
    add_byte(8'h40);
    add_byte(8'hFF);
    add_packet(8'hFC, 8'h94, 8'h20);
    send_payload(1'b1);
    // bad marker on the second packet
    add_header(-1, 8'h00);
    add_byte(8'h43);
    add_byte(8'hFF);
    add_packet(8'hFC, 8'h94, 8'h20);
    add_packet(8'h00, 8'h94, 8'h20);
    add_packet(8'hFD, 8'h9C, 8'h20);
    send_payload(1'b1);
    // skipped packets and the remaining channels
    add_header(-1, 8'h00);
    add_byte(8'h47);
    add_byte(8'hFF);
    add_packet(8'hF8, 8'h14, 8'h20);
    add_packet(8'hFE, 8'h94, 8'h94);
    add_packet(8'hFF, 8'hFF, 8'hFF);
    add_packet(8'hFC, 8'h80, 8'h80);
    add_packet(8'hFC, 8'hC1, 8'hFF);
    add_packet(8'hFC, 8'h98, 8'h00);
    add_packet(8'hFD, 8'h10, 8'h80);
    send_payload(1'b1);
    // truncated payload, then a restart in the middle of a header
    add_header(-1, 8'h00);
    add_byte(8'h43);
    add_byte(8'hFF);
    add_packet(8'hFC, 8'h14, 8'h20);
    add_byte(8'hFC);
    add_byte(8'h94);
    send_payload(1'b1);
    for (i = 0; i < 5; i++) add_byte(GaHeader[63 - 8 * i -: 8]);
    send_payload(1'b1);
    add_header(-1, 8'h00);
    add_byte(8'h41);
    add_byte(8'h00);
    add_packet(8'hFD, 8'h1C, 8'h41);
    send_payload(1'b1);
    // longest packet run with trailing bytes past the position limit
    build_caption_payload(31);
    repeat (30) add_byte(8'hFF);
    send_payload(1'b1);
  endtask

  task automatic test_random_traffic(input int snd_pct, input int rcv_pct, input int count);
    int stop_at;
    send_idle_pct = snd_pct;
    recv_stall_pct = rcv_pct;
    stop_at = bytes_accepted + count;
    while (bytes_accepted < stop_at) send_random_payload();
  endtask

  task automatic test_backpressure_fill();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_req = HoldOffCycles;
    repeat (6) begin
      build_caption_payload(8);
      send_payload(1'b1);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    data_byte_i = '0;
    payload_start_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CfgSelectEnable;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    holdoff_req = 0;
    holdoff_left = 0;
    bytes_accepted = 0;
    pairs_checked = 0;
    errors_checked = 0;
    mismatch_count = 0;
    pos_q = '0;
    hdr_ok = 1'b1;
    proc_on = 1'b0;
    pkts_left = '0;
    pkt_hold = '0;
    cur_chan = '0;
    n_tracks = '0;
    sel_en = 1'b0;
    sel_track = '0;
    for (int i = 0; i < 4; i++) begin
      chan_track[i] = NumTracks;
      track_chan[i] = '0;
    end
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    cfg_write(CfgSelectEnable, 2'd1);
    cfg_write(CfgSelectedTrack, 2'd1);
    test_special_cases();
    settle();
    cfg_write(CfgSelectedTrack, 2'd3);
    test_random_traffic(30, 79, 270);
    settle();
    cfg_write(CfgSelectEnable, 2'd0);
    cfg_write(CfgSelectedTrack, 2'd0);
    test_random_traffic(79, 30, 270);
    settle();
    cfg_write(CfgSelectEnable, 2'd1);
    test_random_traffic(0, 0, 270);
    settle();
    cfg_write(CfgSelectedTrack, 2'd2);
    test_backpressure_fill();
    settle();
    repeat (20) @(posedge clk_i);

    $display("run covered %0d user data bytes, %0d caption pairs, %0d error transactions",
             bytes_accepted, pairs_checked, errors_checked);
    $display("%0d caption tracks found; output held off for %0d cycles once",
             n_tracks, HoldOffCycles);
    if (mismatch_count == 0 && pending_captions.size() == 0) begin
      $display("atsc_cc_caption_extractor_unit_tb: PASS");
    end else begin
      $display("atsc_cc_caption_extractor_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
